/* sv/pewb_pkg.sv */
package pewb_pkg;

	localparam int POS_W = 24;
	localparam int VEL_W = 13;
	localparam int TIME_W = 32;

	// configuration register indexes
	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_RADIUS = 3'd2;
	localparam logic [2:0] REG_GRAV_X = 3'd3;
	localparam logic [2:0] REG_GRAV_Y = 3'd4;
	localparam logic [2:0] REG_PHYS = 3'd5;
	localparam logic [2:0] REG_TSTEP = 3'd6;
	localparam logic [2:0] REG_LIMIT = 3'd7;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_WALLS,
		OP_GRAV,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP
	} op_t;

	typedef struct packed {
		op_t op;
		logic integrate;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic over_limit;
		logic sqrt_done;
		logic div_done;
	} status_t;

endpackage

/* sv/particle_euler_wall_bounce_unit.sv */
// One 2D particle, advanced one tick per input transfer (mode 0) or loaded (mode 1).
// The result sits in its own output register, so the next input can be taken while a
// result waits; a finished item waits in the datapath until that register is free.
// A load, or a tick with physics off (wall checks only), goes straight on to the result
// register; a tick with physics on then adds gravity, checks the speed limit and integrates,
// and when the limit fires the velocity is first scaled by a bit-serial square root and a
// bit-serial divider that scales both components in parallel. One item is computed at
// a time; input is ready again in the cycle after the result has moved into the output
// register.
module particle_euler_wall_bounce_unit #(
	parameter int FRAC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// load_x[23:0], load_y[47:24], load_vx[60:48], load_vy[73:61], zero fill
	input logic [79:0] s_axis_tdata,
	// mode
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// pos_x[23:0], pos_y[47:24], vel_x[60:48], vel_y[73:61], elapsed_time[105:74]
	output logic [111:0] m_axis_tdata,
	// hit_side
	output logic m_axis_tuser,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_wdata
);
	logic [11:0] width_q, height_q, limit_q;
	logic [7:0] radius_q;
	logic signed [9:0] gx_q, gy_q;
	logic phys_q;
	logic [15:0] tstep_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd1024;
			height_q <= 12'd768;
			radius_q <= 8'd1;
			gx_q <= '0;
			gy_q <= '0;
			phys_q <= 1'b0;
			tstep_q <= 16'd655;
			limit_q <= 12'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pewb_pkg::REG_WIDTH: width_q <= cfg_wdata[11:0];
				pewb_pkg::REG_HEIGHT: height_q <= cfg_wdata[11:0];
				pewb_pkg::REG_RADIUS: radius_q <= cfg_wdata[7:0];
				pewb_pkg::REG_GRAV_X: gx_q <= cfg_wdata[9:0];
				pewb_pkg::REG_GRAV_Y: gy_q <= cfg_wdata[9:0];
				pewb_pkg::REG_PHYS: phys_q <= cfg_wdata[0];
				pewb_pkg::REG_TSTEP: tstep_q <= cfg_wdata;
				pewb_pkg::REG_LIMIT: limit_q <= cfg_wdata[11:0];
				default: begin
				end
			endcase
		end
	end

	pewb_pkg::cmd_t cmd;
	pewb_pkg::status_t status;
	logic busy, in_fire;
	logic signed [23:0] px, py;
	logic signed [12:0] vx, vy;
	logic [31:0] et;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	pewb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.in_mode(s_axis_tuser),
		.out_taken(m_axis_tvalid && m_axis_tready),
		.physics_on(phys_q),
		.status(status),
		.cmd(cmd),
		.busy(busy),
		.out_valid(m_axis_tvalid)
	);

	pewb_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.screen_width(width_q),
		.screen_height(height_q),
		.radius(radius_q),
		.gravity_x(gx_q),
		.gravity_y(gy_q),
		.time_step(tstep_q),
		.speed_limit(limit_q),
		.load_x(s_axis_tdata[23:0]),
		.load_y(s_axis_tdata[47:24]),
		.load_vx(s_axis_tdata[60:48]),
		.load_vy(s_axis_tdata[73:61]),
		.pos_x(px),
		.pos_y(py),
		.vel_x(vx),
		.vel_y(vy),
		.hit_side(m_axis_tuser),
		.elapsed_time(et)
	);

	assign m_axis_tdata = {6'd0, et, vy, vx, py, px};
endmodule

/* sv/pewb_datapath.sv */
module pewb_datapath #(
	parameter int FRAC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input pewb_pkg::cmd_t cmd,
	output pewb_pkg::status_t status,
	input logic [11:0] screen_width,
	input logic [11:0] screen_height,
	input logic [7:0] radius,
	input logic signed [9:0] gravity_x,
	input logic signed [9:0] gravity_y,
	input logic [15:0] time_step,
	input logic [11:0] speed_limit,
	input logic signed [pewb_pkg::POS_W-1:0] load_x,
	input logic signed [pewb_pkg::POS_W-1:0] load_y,
	input logic signed [pewb_pkg::VEL_W-1:0] load_vx,
	input logic signed [pewb_pkg::VEL_W-1:0] load_vy,
	output logic signed [pewb_pkg::POS_W-1:0] pos_x,
	output logic signed [pewb_pkg::POS_W-1:0] pos_y,
	output logic signed [pewb_pkg::VEL_W-1:0] vel_x,
	output logic signed [pewb_pkg::VEL_W-1:0] vel_y,
	output logic hit_side,
	output logic [31:0] elapsed_time
);
	localparam int PW = pewb_pkg::POS_W;
	localparam int VW = pewb_pkg::VEL_W;
	localparam int WW = 12 + FRAC_BITS + 2;     // wall values, signed
	localparam int XW = ((WW > PW) ? WW : PW) + 1; // position compare and sum
	localparam int GW = VW + 2;                 // velocity after gravity
	localparam int SW = 2 * GW;                 // squared length
	localparam int RW = SW;                     // root, holds partial values too
	localparam int NW = GW + 12;                // |v| * limit
	localparam int SQ_STEPS = SW / 2;
	localparam int CW = $clog2(NW + 1);
	localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	logic signed [PW-1:0] px_q, py_q;
	logic signed [VW-1:0] vx_q, vy_q;
	logic hit_q;
	logic [31:0] time_q;
	logic signed [GW-1:0] gx_q, gy_q;
	logic [SW-1:0] rem_q, bit_q;
	logic [RW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] nx_q, ny_q;
	logic [NW-1:0] rx_q, ry_q, qx_q, qy_q;
	logic signed [PW-1:0] opx_q, opy_q;
	logic signed [VW-1:0] ovx_q, ovy_q;
	logic ohit_q;
	logic [31:0] otime_q;

	// position saturation
	function automatic logic signed [PW-1:0] sat_p(input logic signed [XW-1:0] v);
		if (v > XW'(PMAX)) return PMAX;
		if (v < XW'(PMIN)) return PMIN;
		return v[PW-1:0];
	endfunction

	function automatic logic signed [VW-1:0] sat_v(input logic signed [GW:0] v);
		if (v > (GW+1)'(VMAX)) return VMAX;
		if (v < (GW+1)'(VMIN)) return VMIN;
		return v[VW-1:0];
	endfunction

	function automatic logic signed [VW-1:0] neg_v(input logic signed [VW-1:0] v);
		return sat_v(-(GW+1)'(v));
	endfunction

	// wall values
	logic signed [WW-1:0] r_w, right_w, bottom_w;
	assign r_w = WW'({radius, {FRAC_BITS{1'b0}}});
	assign right_w = WW'({screen_width, {FRAC_BITS{1'b0}}}) - r_w;
	assign bottom_w = WW'({screen_height, {FRAC_BITS{1'b0}}}) - r_w;

	// four checks in order
	logic signed [PW-1:0] wx, wy;
	logic signed [VW-1:0] wvx, wvy;
	logic whit;
	always_comb begin
		wx = px_q;
		wy = py_q;
		wvx = vx_q;
		wvy = vy_q;
		whit = 1'b0;
		if (XW'(wx) > XW'(right_w)) begin
			wx = sat_p(XW'(right_w));
			wvx = neg_v(wvx);
			whit = 1'b1;
		end
		if (XW'(wx) < XW'(r_w)) begin
			wx = sat_p(XW'(r_w));
			wvx = neg_v(wvx);
			whit = 1'b1;
		end
		if (XW'(wy) > XW'(bottom_w)) begin
			wy = sat_p(XW'(bottom_w));
			wvy = neg_v(wvy);
			whit = 1'b1;
		end
		if (XW'(wy) < XW'(r_w)) begin
			wy = sat_p(XW'(r_w));
			wvy = neg_v(wvy);
			whit = 1'b1;
		end
	end

	// magnitudes and limit compare
	logic [GW-1:0] ax, ay;
	logic [SW-1:0] sq, lim_sq;
	assign ax = gx_q[GW-1] ? GW'(-gx_q) : GW'(gx_q);
	assign ay = gy_q[GW-1] ? GW'(-gy_q) : GW'(gy_q);
	assign sq = SW'(ax) * SW'(ax) + SW'(ay) * SW'(ay);
	assign lim_sq = SW'(speed_limit) * SW'(speed_limit);
	assign status.over_limit = sq > lim_sq;
	assign status.sqrt_done = bit_q == '0;
	assign status.div_done = cnt_q == '0;

	// one root digit
	logic [SW-1:0] trial;
	assign trial = SW'(root_q) + bit_q;

	// one quotient bit per component
	logic [NW:0] tx, ty;
	assign tx = {rx_q, nx_q[NW-1]} - (NW+1)'(root_q);
	assign ty = {ry_q, ny_q[NW-1]} - (NW+1)'(root_q);

	// scaled component, final velocity and integration
	logic signed [GW:0] fx, fy;
	logic signed [VW-1:0] svx, svy;
	always_comb begin
		if (status.over_limit) begin
			fx = gx_q[GW-1] ? -(GW+1)'(qx_q) : (GW+1)'(qx_q);
			fy = gy_q[GW-1] ? -(GW+1)'(qy_q) : (GW+1)'(qy_q);
		end else begin
			fx = (GW+1)'(gx_q);
			fy = (GW+1)'(gy_q);
		end
		svx = sat_v(fx);
		svy = sat_v(fy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			vx_q <= '0;
			vy_q <= '0;
			hit_q <= 1'b0;
			time_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
			opx_q <= '0;
			opy_q <= '0;
			ovx_q <= '0;
			ovy_q <= '0;
			ohit_q <= 1'b0;
			otime_q <= '0;
		end else begin
			unique case (cmd.op)
				pewb_pkg::OP_LOAD: begin
					px_q <= load_x;
					py_q <= load_y;
					vx_q <= load_vx;
					vy_q <= load_vy;
					hit_q <= 1'b0;
				end
				pewb_pkg::OP_WALLS: begin
					px_q <= wx;
					py_q <= wy;
					vx_q <= wvx;
					vy_q <= wvy;
					hit_q <= whit;
					time_q <= time_q + 32'(time_step);
				end
				pewb_pkg::OP_GRAV: begin
					gx_q <= GW'(vx_q) + GW'(gravity_x);
					gy_q <= GW'(vy_q) + GW'(gravity_y);
				end
				pewb_pkg::OP_SQRT_INIT: begin
					rem_q <= sq;
					root_q <= '0;
					bit_q <= SW'(1) << (SW - 2);
				end
				pewb_pkg::OP_SQRT_STEP: begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						root_q <= RW'((SW'(root_q) >> 1) + bit_q);
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
				pewb_pkg::OP_DIV_INIT: begin
					nx_q <= NW'(ax) * NW'(speed_limit);
					ny_q <= NW'(ay) * NW'(speed_limit);
					rx_q <= '0;
					ry_q <= '0;
					qx_q <= '0;
					qy_q <= '0;
					cnt_q <= CW'(NW);
				end
				pewb_pkg::OP_DIV_STEP: begin
					nx_q <= nx_q << 1;
					ny_q <= ny_q << 1;
					rx_q <= tx[NW] ? {rx_q[NW-2:0], nx_q[NW-1]} : tx[NW-1:0];
					ry_q <= ty[NW] ? {ry_q[NW-2:0], ny_q[NW-1]} : ty[NW-1:0];
					qx_q <= {qx_q[NW-2:0], ~tx[NW]};
					qy_q <= {qy_q[NW-2:0], ~ty[NW]};
					cnt_q <= cnt_q - CW'(1);
				end
				default: begin
				end
			endcase
			if (cmd.integrate) begin
				vx_q <= svx;
				vy_q <= svy;
				px_q <= sat_p(XW'(px_q) + XW'(svx));
				py_q <= sat_p(XW'(py_q) + XW'(svy));
			end
			// result register
			if (cmd.capture) begin
				opx_q <= px_q;
				opy_q <= py_q;
				ovx_q <= vx_q;
				ovy_q <= vy_q;
				ohit_q <= hit_q;
				otime_q <= time_q;
			end
		end
	end

	assign pos_x = opx_q;
	assign pos_y = opy_q;
	assign vel_x = ovx_q;
	assign vel_y = ovy_q;
	assign hit_side = ohit_q;
	assign elapsed_time = otime_q;
endmodule

/* sv/pewb_ctrl.sv */
module pewb_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic in_mode,
	input logic out_taken,
	input logic physics_on,
	input pewb_pkg::status_t status,
	output pewb_pkg::cmd_t cmd,
	output logic busy,
	output logic out_valid
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GRAV = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_DIVI = 3'd4;
	localparam logic [2:0] S_DIV = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic valid_q;
	logic out_free;

	// result register can take a new result this cycle
	assign out_free = !valid_q || out_taken;

	// command decode
	always_comb begin
		cmd.op = pewb_pkg::OP_NONE;
		cmd.integrate = 1'b0;
		cmd.capture = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) cmd.op = in_mode ? pewb_pkg::OP_LOAD : pewb_pkg::OP_WALLS;
			end
			S_GRAV: cmd.op = pewb_pkg::OP_GRAV;
			S_CHECK: begin
				if (status.over_limit) cmd.op = pewb_pkg::OP_SQRT_INIT;
				else cmd.integrate = 1'b1;
			end
			S_SQRT: begin
				if (!status.sqrt_done) cmd.op = pewb_pkg::OP_SQRT_STEP;
			end
			S_DIVI: cmd.op = pewb_pkg::OP_DIV_INIT;
			S_DIV: begin
				if (status.div_done) cmd.integrate = 1'b1;
				else cmd.op = pewb_pkg::OP_DIV_STEP;
			end
			S_DONE: cmd.capture = out_free;
			default: begin
			end
		endcase
	end

	// sequencing and result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) valid_q <= 1'b1;
			else if (out_taken) valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_mode || !physics_on) state_q <= S_DONE;
						else state_q <= S_GRAV;
					end
				end
				S_GRAV: state_q <= S_CHECK;
				S_CHECK: state_q <= status.over_limit ? S_SQRT : S_DONE;
				S_SQRT: if (status.sqrt_done) state_q <= S_DIVI;
				S_DIVI: state_q <= S_DIV;
				S_DIV: if (status.div_done) state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign out_valid = valid_q;
endmodule

/* sv/pewb_checker.sv */
module pewb_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [111:0] m_axis_tdata,
	input logic m_axis_tuser
);
	// one input at a time: busy right after a transfer in
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken back to back");

	// a pending result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// a load result reports no hit
	a_load_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid
			|-> ##2 (m_axis_tvalid && !m_axis_tuser))
		else $error("load result wrong");

	// result appears only after an accepted input
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without input");
endmodule

bind particle_euler_wall_bounce_unit pewb_checker u_pewb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
